FILE: rtl/gn2d_pkg.sv
// Package: shared widths, operation and gradient codes, table write record.
`default_nettype none
package gn2d_pkg;

  localparam int COORD_W  = 20;
  localparam int ENTRY_W  = 8;
  localparam int NOISE_W  = 16;
  localparam int FADE_W   = 16;
  localparam int DIAG_Q15 = 23170;
  localparam int AXIS_SH  = 15;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // gradient select, hash mod 8
  localparam logic [2:0] GRAD_PP = 3'd0;
  localparam logic [2:0] GRAD_PM = 3'd1;
  localparam logic [2:0] GRAD_MP = 3'd2;
  localparam logic [2:0] GRAD_MM = 3'd3;
  localparam logic [2:0] GRAD_XP = 3'd4;
  localparam logic [2:0] GRAD_XM = 3'd5;
  localparam logic [2:0] GRAD_YP = 3'd6;
  localparam logic [2:0] GRAD_YM = 3'd7;

  typedef struct packed {
    logic               we;
    logic [ENTRY_W-1:0] idx;
    logic [ENTRY_W-1:0] val;
  } tbl_wr_t;

endpackage
`default_nettype wire

FILE: rtl/gn2d_if.sv
// Interfaces: input item channel and result item channel.
`default_nettype none
interface gn2d_in_if;
  import gn2d_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [ENTRY_W-1:0] entry_index;
  logic [ENTRY_W-1:0] entry_value;
  modport source (output valid, op, coord_x, coord_y, entry_index, entry_value, input ready);
  modport sink   (input valid, op, coord_x, coord_y, entry_index, entry_value, output ready);
endinterface

interface gn2d_out_if;
  import gn2d_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [NOISE_W-1:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/gn2d_ram.sv
// Generic single-write, single-read RAM with registered read.
`default_nettype none
module gn2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/gn2d_fade.sv
// Fade curve 6t^5-15t^4+10t^3 in Q16, four register stages.
`default_nettype none
module gn2d_fade #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [FRAC_BITS-1:0] frac_i,
  output logic      [15:0]          fade_o
);
  import gn2d_pkg::*;

  localparam logic [35:0] P_TEN = 36'd10 << 32;

  logic [15:0] t;
  logic [15:0] t1_q;
  logic [31:0] tt_q;
  logic [31:0] t3_full;
  logic [15:0] t3_q;
  logic [35:0] p_d;
  logic [35:0] p_q;
  logic [33:0] pl_q;
  logic [33:0] ph_q;
  logic [52:0] sum;

  assign t       = 16'(frac_i) << (16 - FRAC_BITS);
  assign t3_full = 32'(tt_q[31:16]) * 32'(t1_q);
  assign p_d     = 36'(tt_q) * 36'd6 + P_TEN - ((36'(t1_q) * 36'd15) << 16);
  assign sum     = 53'({ph_q, 18'b0}) + 53'(pl_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q   <= t;
      tt_q   <= 32'(t) * 32'(t);
      t3_q   <= t3_full[31:16];
      p_q    <= p_d;
      pl_q   <= 34'(t3_q) * 34'(p_q[17:0]);
      ph_q   <= 34'(t3_q) * 34'(p_q[35:18]);
      fade_o <= sum[32 +: FADE_W];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/gradient_noise_2d.sv
// Top level: pipelined 2D gradient noise with loadable permutation table.
//
//  channel | dir | payload                                       | result
//  in_i    | in  | op, coord_x, coord_y, entry_index, entry_value | write: none
//  out_o   | out | noise_value (signed Q14, saturated)           | one per evaluate
//
// Throughput one item per cycle while out_o is not stalled; an evaluate passes
// through lookup, hash, dot, blend and rounding stages plus the output reg.
// The permutation table lives in six RAM copies (one per lookup) written in
// step with the item stream, so each read sees exactly the preceding writes.
// After reset a clearing pass over all TABLE_SIZE entries loads the identity table;
// in_i.ready stays low meanwhile.
// A stall on out_o freezes the whole pipeline; ready then falls at the input.
`default_nettype none
module gradient_noise_2d #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 12
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  gn2d_in_if.sink    in_i,
  gn2d_out_if.source out_o
);
  import gn2d_pkg::*;

  localparam int AW    = $clog2(TABLE_SIZE);
  localparam int DW    = FRAC_BITS + 2;   // corner offsets and their sums
  localparam int NW    = FRAC_BITS + 17;  // dot products
  localparam int DDW   = NW + 1;
  localparam int MW    = DDW + 17;
  localparam int IXW   = NW + 1;
  localparam int DXW   = IXW + 1;
  localparam int MW2   = DXW + 17;
  localparam int NNW   = MW2 + 1;
  localparam int ONE_I = 1 << FRAC_BITS;
  localparam int Q_SH  = FRAC_BITS + 17;

  localparam logic signed [NW-1:0]  DIAG  = NW'(DIAG_Q15);
  localparam logic signed [NNW-1:0] RND   = NNW'(1) <<< (FRAC_BITS + 16);
  localparam logic signed [NNW-1:0] Q_MAX = NNW'(32767);
  localparam logic signed [NNW-1:0] Q_MIN = -NNW'(32768);

  function automatic logic signed [NW-1:0] corner_dot(
    input logic [2:0] g,
    input logic signed [DW-1:0] dx,
    input logic signed [DW-1:0] dy
  );
    logic signed [DW-1:0] s;
    logic signed [NW-1:0] r;
    s = '0;
    r = '0;
    case (g)
      GRAD_PP: begin s = dx + dy; r = NW'(s) * DIAG; end
      GRAD_PM: begin s = dx - dy; r = NW'(s) * DIAG; end
      GRAD_MP: begin s = dy - dx; r = NW'(s) * DIAG; end
      GRAD_MM: begin s = -dx - dy; r = NW'(s) * DIAG; end
      GRAD_XP: r = NW'(dx) <<< AXIS_SH;
      GRAD_XM: r = -(NW'(dx) <<< AXIS_SH);
      GRAD_YP: r = NW'(dy) <<< AXIS_SH;
      default: r = -(NW'(dy) <<< AXIS_SH);
    endcase
    return r;
  endfunction

  // Global advance: the whole pipe moves unless the output is held.
  logic adv, acc, in_rdy;
  logic out_valid_q;
  logic signed [NOISE_W-1:0] noise_q;

  // clearing pass after reset
  logic          clr_busy_q;
  logic [AW-1:0] clr_cnt_q;

  assign adv    = !out_valid_q || out_o.ready;
  assign in_rdy = adv && !clr_busy_q;
  assign acc    = in_i.valid && in_rdy;
  assign in_i.ready = in_rdy;
  assign out_o.valid       = out_valid_q;
  assign out_o.noise_value = noise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= AW'(clr_cnt_q + AW'(1));
      if (clr_cnt_q == AW'(TABLE_SIZE - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // stage 0: cell split, first lookups
  logic [AW-1:0]        x0, y0, x1, y1;
  logic [FRAC_BITS-1:0] fx, fy;
  logic                 wr_ok;

  assign x0    = AW'(in_i.coord_x >> FRAC_BITS);
  assign y0    = AW'(in_i.coord_y >> FRAC_BITS);
  assign x1    = AW'(x0 + AW'(1));
  assign y1    = AW'(y0 + AW'(1));
  assign fx    = in_i.coord_x[FRAC_BITS-1:0];
  assign fy    = in_i.coord_y[FRAC_BITS-1:0];
  assign wr_ok = (in_i.op == OP_WRITE) && (32'(in_i.entry_index) < TABLE_SIZE);

  logic               wa_we, wb_we;
  logic [AW-1:0]      wa_addr, wb_addr;
  logic [ENTRY_W-1:0] wa_data, wb_data;
  logic [ENTRY_W-1:0] py0, py1;

  assign wa_we   = clr_busy_q || (acc && wr_ok);
  assign wa_addr = clr_busy_q ? clr_cnt_q : AW'(in_i.entry_index);
  assign wa_data = clr_busy_q ? ENTRY_W'(clr_cnt_q) : in_i.entry_value;

  gn2d_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_y0 (
    .clk_i, .we_i(wa_we), .waddr_i(wa_addr), .wdata_i(wa_data),
    .re_i(adv), .raddr_i(y0), .rdata_o(py0));
  gn2d_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_y1 (
    .clk_i, .we_i(wa_we), .waddr_i(wa_addr), .wdata_i(wa_data),
    .re_i(adv), .raddr_i(y1), .rdata_o(py1));

  // fade curves run alongside, result lines up with stage 4
  logic [FADE_W-1:0] fade_u, fade_v;
  gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
    .clk_i, .en_i(adv), .frac_i(fx), .fade_o(fade_u));
  gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
    .clk_i, .en_i(adv), .frac_i(fy), .fade_o(fade_v));

  // stage 1: corner hash lookups
  logic                 s1_valid_q, s1_op_q;
  tbl_wr_t              s1_wr_q;
  logic [AW-1:0]        s1_x0_q, s1_x1_q;
  logic [FRAC_BITS-1:0] s1_fx_q, s1_fy_q;
  logic [ENTRY_W-1:0]   h00, h10, h01, h11;

  assign wb_we   = clr_busy_q || (adv && s1_wr_q.we);
  assign wb_addr = clr_busy_q ? clr_cnt_q : AW'(s1_wr_q.idx);
  assign wb_data = clr_busy_q ? ENTRY_W'(clr_cnt_q) : s1_wr_q.val;

  gn2d_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_h00 (
    .clk_i, .we_i(wb_we), .waddr_i(wb_addr), .wdata_i(wb_data),
    .re_i(adv), .raddr_i(AW'(s1_x0_q + AW'(py0))), .rdata_o(h00));
  gn2d_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_h10 (
    .clk_i, .we_i(wb_we), .waddr_i(wb_addr), .wdata_i(wb_data),
    .re_i(adv), .raddr_i(AW'(s1_x1_q + AW'(py0))), .rdata_o(h10));
  gn2d_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_h01 (
    .clk_i, .we_i(wb_we), .waddr_i(wb_addr), .wdata_i(wb_data),
    .re_i(adv), .raddr_i(AW'(s1_x0_q + AW'(py1))), .rdata_o(h01));
  gn2d_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_h11 (
    .clk_i, .we_i(wb_we), .waddr_i(wb_addr), .wdata_i(wb_data),
    .re_i(adv), .raddr_i(AW'(s1_x1_q + AW'(py1))), .rdata_o(h11));

  // stage 2: corner dot products
  logic [FRAC_BITS-1:0] s2_fx_q, s2_fy_q;
  logic signed [DW-1:0] dx0, dy0, dx1, dy1;

  assign dx0 = DW'($signed({1'b0, s2_fx_q}));
  assign dy0 = DW'($signed({1'b0, s2_fy_q}));
  assign dx1 = dx0 - DW'(ONE_I);
  assign dy1 = dy0 - DW'(ONE_I);

  logic signed [NW-1:0]  s3_n00_q, s3_n10_q, s3_n01_q, s3_n11_q;
  logic signed [NW-1:0]  s4_n00_q, s4_n01_q, s5_n00_q, s5_n01_q;
  logic signed [DDW-1:0] s4_d0_q, s4_d1_q;
  logic signed [MW-1:0]  s5_m0_q, s5_m1_q;
  logic [FADE_W-1:0]     s5_v_q, s6_v_q, s7_v_q;
  logic signed [IXW-1:0] s6_ix0_q, s6_ix1_q, s7_ix0_q, s8_ix0_q;
  logic signed [DXW-1:0] s7_dix_q;
  logic signed [MW2-1:0] s8_my_q;
  logic signed [NNW-1:0] s9_n_q, q;
  logic signed [NOISE_W-1:0] noise_d;

  assign q = (s9_n_q + RND) >>> Q_SH;

  always_comb begin
    if (q > Q_MAX) begin
      noise_d = NOISE_W'(Q_MAX);
    end else if (q < Q_MIN) begin
      noise_d = NOISE_W'(Q_MIN);
    end else begin
      noise_d = NOISE_W'(q);
    end
  end

  // eval flags per stage
  logic s2_ev_q, s3_ev_q, s4_ev_q, s5_ev_q, s6_ev_q, s7_ev_q, s8_ev_q, s9_ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_wr_q.we  <= 1'b0;
      s1_wr_q.idx <= '0;
      s1_wr_q.val <= '0;
      s2_ev_q     <= 1'b0;
      s3_ev_q     <= 1'b0;
      s4_ev_q     <= 1'b0;
      s5_ev_q     <= 1'b0;
      s6_ev_q     <= 1'b0;
      s7_ev_q     <= 1'b0;
      s8_ev_q     <= 1'b0;
      s9_ev_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= acc;
      s1_wr_q.we  <= acc && wr_ok;
      s1_wr_q.idx <= in_i.entry_index;
      s1_wr_q.val <= in_i.entry_value;
      s2_ev_q     <= s1_valid_q && (s1_op_q == OP_EVAL);
      s3_ev_q     <= s2_ev_q;
      s4_ev_q     <= s3_ev_q;
      s5_ev_q     <= s4_ev_q;
      s6_ev_q     <= s5_ev_q;
      s7_ev_q     <= s6_ev_q;
      s8_ev_q     <= s7_ev_q;
      s9_ev_q     <= s8_ev_q;
      out_valid_q <= s9_ev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q     <= in_i.op;
      s1_x0_q     <= x0;
      s1_x1_q     <= x1;
      s1_fx_q     <= fx;
      s1_fy_q     <= fy;
      s2_fx_q     <= s1_fx_q;
      s2_fy_q     <= s1_fy_q;
      s3_n00_q    <= corner_dot(h00[2:0], dx0, dy0);
      s3_n10_q    <= corner_dot(h10[2:0], dx1, dy0);
      s3_n01_q    <= corner_dot(h01[2:0], dx0, dy1);
      s3_n11_q    <= corner_dot(h11[2:0], dx1, dy1);
      s4_d0_q     <= DDW'(s3_n10_q) - DDW'(s3_n00_q);
      s4_d1_q     <= DDW'(s3_n11_q) - DDW'(s3_n01_q);
      s4_n00_q    <= s3_n00_q;
      s4_n01_q    <= s3_n01_q;
      s5_m0_q     <= MW'(s4_d0_q) * MW'($signed({1'b0, fade_u}));
      s5_m1_q     <= MW'(s4_d1_q) * MW'($signed({1'b0, fade_u}));
      s5_n00_q    <= s4_n00_q;
      s5_n01_q    <= s4_n01_q;
      s5_v_q      <= fade_v;
      s6_ix0_q    <= IXW'(((MW'(s5_n00_q) <<< 16) + s5_m0_q) >>> 16);
      s6_ix1_q    <= IXW'(((MW'(s5_n01_q) <<< 16) + s5_m1_q) >>> 16);
      s6_v_q      <= s5_v_q;
      s7_dix_q    <= DXW'(s6_ix1_q) - DXW'(s6_ix0_q);
      s7_ix0_q    <= s6_ix0_q;
      s7_v_q      <= s6_v_q;
      s8_my_q     <= MW2'(s7_dix_q) * MW2'($signed({1'b0, s7_v_q}));
      s8_ix0_q    <= s7_ix0_q;
      s9_n_q      <= (NNW'(s8_ix0_q) <<< 16) + NNW'(s8_my_q);
      noise_q     <= noise_d;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/gn2d_checker.sv
// Port checker for gradient_noise_2d and its bind.
`default_nettype none
module gn2d_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] noise_value_i
);
  // table load after reset keeps the input shut
  a_clear_blocks: assert property (@(posedge clk_i) !rst_ni |=> !in_ready_i)
    else $error("input ready right after reset");

  a_no_out_after_rst: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result shown right after reset");

  // pipe stalls as a whole
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_i && out_valid_i) |-> out_ready_i)
    else $error("input taken while output stalled");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(noise_value_i)))
    else $error("stalled result dropped or changed");
endmodule

bind gradient_noise_2d gn2d_checker u_gn2d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .noise_value_i(out_o.noise_value)
);
`default_nettype wire
